>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> hdl/tfct_pkg.sv
// ----------------------------------------------------------------------------
// tfct_pkg
// Types and constants of the tile frame completion tracker.
// ----------------------------------------------------------------------------
package tfct_pkg;

    localparam int CFG_W        = 5;   // tile count register width
    localparam int FRAME_W      = 32;
    localparam int OPCODE_W     = 2;
    localparam int OUT_TDATA_W  = 40;  // frame + running flag, padded to bytes
    localparam int RESULT_LIMIT = 16;  // most releases per walk
    localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

    typedef enum logic [OPCODE_W-1:0] {
        OP_TILE   = 2'd0,
        OP_START  = 2'd1,
        OP_REFUSE = 2'd2
    } opcode_t;

    typedef enum logic {
        KIND_RELEASE = 1'b0,
        KIND_DROP    = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TILE_RD,
        ST_WALK_RD,
        ST_WALK_CHK
    } state_t;

endpackage

>>> hdl/tile_frame_completion_tracker.sv
// ----------------------------------------------------------------------------
// tile_frame_completion_tracker
// Counts tiles per frame in a window of slots and releases frames in order.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream: s_tuser carries the opcode (tile, start, refusal), s_tdata
//    the frame number of a tile. One word is taken per command.
//  - Master stream: one word per released frame (m_tuser = 0) or per tile
//    dropped outside the window (m_tuser = 1); m_tlast marks the final word
//    caused by one input word. m_tdata also carries the running flag.
//  - cfg channel: writes tile_count (tiles per frame); write it only when idle, the block itself does not enforce this.
//  - Timing: start, refusal and dropped tiles are handled in the idle state.
//    A counted tile takes a memory read, then an update. If it completes a
//    frame while running, the release walk reads, then checks each head slot,
//    with at most 16 frames per walk. The registered slot memory read sets
//    this.
//  - Reset: all slots empty (valid bits cleared at once), head frame 0,
//    not running, tile_count 1. No clearing pass.
//  - Stall: results go through a single output register; a stalled sink
//    holds the walk at the check step and keeps s_tready low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tile_frame_completion_tracker
    import tfct_pkg::*;
#(
    parameter int WINDOW    = 16,  // slots in the reorder window
    parameter int MAX_TILES = 16   // largest tile count honoured
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // slave stream
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [FRAME_W-1:0]       s_tdata,   // [31:0] frame_number
    input  logic [OPCODE_W-1:0]      s_tuser,   // [1:0] opcode
    // master stream
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_TDATA_W-1:0]   m_tdata,   // [31:0] out_frame, [32] running
    output logic                     m_tuser,   // [0] kind
    output logic                     m_tlast,
    // configuration
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_W-1:0]         cfg_data   // tile_count
);

    localparam int SW = $clog2(WINDOW);         // slot index width
    localparam int TW = $clog2(MAX_TILES + 1);  // tile counter width

    // ---------------------------------------------------------------- state
    state_t               state_reg, state_next;
    logic                 run_reg, run_next;
    logic [FRAME_W-1:0]   head_frame_reg, head_frame_next;
    logic [SW-1:0]        head_slot_reg, head_slot_next;
    logic [SW-1:0]        slot_reg, slot_next;
    logic [CNT_W-1:0]     walk_cnt_reg, walk_cnt_next;
    logic [WINDOW-1:0]    slot_valid_reg, slot_valid_next;
    logic [CFG_W-1:0]     tile_cfg_reg;

    // output word register
    logic                 m_valid_reg;
    logic                 kind_reg;
    logic [FRAME_W-1:0]   frame_out_reg;
    logic                 running_out_reg;
    logic                 last_reg;

    // slot tile counters; an entry with its valid bit low reads as zero
    logic [TW-1:0]        tile_mem [WINDOW];
    logic [TW-1:0]        rd_data_reg;
    logic [SW-1:0]        rd_addr;
    logic                 mem_we;
    logic [TW-1:0]        mem_wdata;

    // ---------------------------------------------------------------- datapath
    logic [TW-1:0]        need;
    logic [FRAME_W-1:0]   frame_offset;
    logic                 out_of_window;
    logic [SW:0]          slot_sum;
    logic [SW-1:0]        slot_calc;
    logic [TW-1:0]        tiles_cur;
    logic [TW-1:0]        tiles_inc;
    logic [TW-1:0]        head_tiles;
    logic                 head_done;
    logic                 out_free;
    logic                 out_load;
    logic                 out_kind;
    logic [FRAME_W-1:0]   out_frame;
    logic                 out_last;

    // effective tile count: zero acts as one, oversize clips to MAX_TILES
    always_comb
    begin
        if (tile_cfg_reg == '0)
            need = TW'(1);
        else if (32'(tile_cfg_reg) > MAX_TILES)
            need = TW'(MAX_TILES);
        else
            need = TW'(tile_cfg_reg);
    end

    // window test is modulo 2^32 from the head frame
    assign frame_offset  = s_tdata - head_frame_reg;
    assign out_of_window = (frame_offset >= 32'(WINDOW));
    assign slot_sum      = {1'b0, head_slot_reg} + {1'b0, frame_offset[SW-1:0]};
    assign slot_calc     = (32'(slot_sum) >= WINDOW) ? SW'(32'(slot_sum) - WINDOW)
                                                     : slot_sum[SW-1:0];

    assign tiles_cur  = slot_valid_reg[slot_reg] ? rd_data_reg : '0;
    assign tiles_inc  = tiles_cur + TW'(1);
    assign head_tiles = slot_valid_reg[head_slot_reg] ? rd_data_reg : '0;
    assign head_done  = (head_tiles >= need) && (head_tiles != '0);

    assign out_free  = !m_valid_reg || m_tready;
    assign mem_wdata = tiles_inc;
    assign cfg_ready = 1'b1;

    // ---------------------------------------------------------------- control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            run_reg        <= 1'b0;
            head_frame_reg <= '0;
            head_slot_reg  <= '0;
            slot_reg       <= '0;
            walk_cnt_reg   <= '0;
            slot_valid_reg <= '0;
            tile_cfg_reg   <= CFG_W'(1);
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            run_reg        <= run_next;
            head_frame_reg <= head_frame_next;
            head_slot_reg  <= head_slot_next;
            slot_reg       <= slot_next;
            walk_cnt_reg   <= walk_cnt_next;
            slot_valid_reg <= slot_valid_next;
            if (cfg_valid)
                tile_cfg_reg <= cfg_data;
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        run_next        = run_reg;
        head_frame_next = head_frame_reg;
        head_slot_next  = head_slot_reg;
        slot_next       = slot_reg;
        walk_cnt_next   = walk_cnt_reg;
        slot_valid_next = slot_valid_reg;
        rd_addr         = head_slot_reg;
        mem_we          = 1'b0;
        s_tready        = 1'b0;
        out_load        = 1'b0;
        out_kind        = KIND_RELEASE;
        out_frame       = head_frame_reg - 32'd1;  // last released frame
        out_last        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = out_free;
                rd_addr  = slot_calc;
                if (s_tvalid && out_free)
                begin
                    case (s_tuser)
                        OP_START:  run_next = 1'b1;
                        OP_REFUSE: run_next = 1'b0;
                        OP_TILE:
                        begin
                            if (out_of_window)
                            begin
                                out_load  = 1'b1;
                                out_kind  = KIND_DROP;
                                out_frame = s_tdata;
                                out_last  = 1'b1;
                            end
                            else
                            begin
                                slot_next  = slot_calc;
                                state_next = ST_TILE_RD;
                            end
                        end
                        default: ;  // unused opcode
                    endcase
                end
            end

            ST_TILE_RD:
            begin
                state_next = ST_IDLE;
                // a tile for an already complete frame is absorbed
                if (!((tiles_cur >= need) && (tiles_cur != '0)))
                begin
                    mem_we                    = 1'b1;
                    slot_valid_next[slot_reg] = 1'b1;
                    if ((tiles_inc >= need) && run_reg)
                    begin
                        walk_cnt_next = '0;
                        state_next    = ST_WALK_RD;
                    end
                end
            end

            ST_WALK_RD:
                state_next = ST_WALK_CHK;

            ST_WALK_CHK:
            begin
                // one release behind: the previous frame goes out once we
                // know whether it was the final one of this walk
                if (head_done && (walk_cnt_reg != CNT_W'(RESULT_LIMIT)))
                begin
                    if ((walk_cnt_reg == '0) || out_free)
                    begin
                        out_load                       = (walk_cnt_reg != '0);
                        slot_valid_next[head_slot_reg] = 1'b0;
                        head_frame_next                = head_frame_reg + 32'd1;
                        head_slot_next = (32'(head_slot_reg) == WINDOW - 1) ? '0
                                         : head_slot_reg + SW'(1);
                        walk_cnt_next  = walk_cnt_reg + CNT_W'(1);
                        state_next     = ST_WALK_RD;
                    end
                end
                else if (walk_cnt_reg == '0)
                    state_next = ST_IDLE;
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    out_last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            tile_mem[slot_reg] <= mem_wdata;
        rd_data_reg <= tile_mem[rd_addr];
    end

    // ---------------------------------------------------------------- output
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            kind_reg        <= out_kind;
            frame_out_reg   <= out_frame;
            running_out_reg <= run_reg;
            last_reg        <= out_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {(OUT_TDATA_W - FRAME_W - 1)'(0), running_out_reg, frame_out_reg};

    // ---------------------------------------------------------------- checks
    `ASSERT_ALWAYS(a_walk_limit, clk, rst_n, walk_cnt_reg <= CNT_W'(RESULT_LIMIT),
        "walk released more frames than allowed")
    `ASSERT_ALWAYS(a_head_slot_range, clk, rst_n, 32'(head_slot_reg) < WINDOW,
        "head slot outside window")
    `ASSERT_IMPLIES(a_walk_ends_last, clk, rst_n,
        (state_reg == ST_WALK_CHK) && (state_next == ST_IDLE) && (walk_cnt_reg != '0),
        out_load && out_last, "walk ended without final word")

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tile frame completion tracker: an in-bench copy
// of the slot window predicts every released or dropped frame word, which is
// compared field by field with the master stream under varied idle patterns.
// ----------------------------------------------------------------------------
module tb;
    import tfct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = 16;   // window depth of the DUT
    localparam int TILES_CAP    = 16;   // largest honoured tile count
    localparam int WALK_CYCLES  = 40;   // covers the longest walk, rounded up
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        kind_t              kind;
        logic [FRAME_W-1:0] frame;
        logic               running;
        logic               last;
    } frame_word_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [FRAME_W-1:0]     s_tdata = '0;   // [31:0] frame_number
    logic [OPCODE_W-1:0]    s_tuser = '0;   // [1:0] opcode
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;        // [31:0] out_frame, [32] running
    logic                   m_tuser;        // [0] kind
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_data = '0;  // tile_count

    tile_frame_completion_tracker u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Window tracker: bench copy of the slot state
    // ------------------------------------------------------------------
    logic               slot_held  [SLOTS];
    int unsigned        slot_tally [SLOTS];
    logic [FRAME_W-1:0] head_no    = '0;
    int unsigned        head_idx   = 0;
    logic               acq_on     = 1'b0;
    logic [CFG_W-1:0]   tiles_cfg  = 5'd1;

    frame_word_t        pending_words[$];   // released/dropped words still due

    int err_count   = 0;
    int words_in    = 0;
    int releases    = 0;
    int drops       = 0;
    int cfg_writes  = 0;

    int src_idle_pct  = 0;
    int sink_stall_pct = 0;

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_held[i]  = 1'b0;
            slot_tally[i] = 0;
        end
    end

    // 0 counts as 1, anything past the cap counts as the cap
    function automatic int unsigned tiles_per_frame();
        int unsigned t;
        t = 32'(tiles_cfg);
        if (t == 0)
            t = 1;
        if (t > TILES_CAP)
            t = TILES_CAP;
        return t;
    endfunction

    // append one expected word at the tail of the queue
    function automatic void queue_word(input frame_word_t w);
        pending_words = {pending_words, w};
    endfunction

    // Apply one accepted word to the tracker and queue the words it causes.
    function automatic void track_word(input logic [OPCODE_W-1:0] op,
                                       input logic [FRAME_W-1:0] frame_no);
        logic [FRAME_W-1:0] offset;
        int unsigned        slot;
        int unsigned        need;
        int unsigned        idx;
        int                 n;
        frame_word_t        w;

        need = tiles_per_frame();
        n    = 0;
        case (op)
            OP_START:  acq_on = 1'b1;
            OP_REFUSE: acq_on = 1'b0;
            OP_TILE:
            begin
                offset = frame_no - head_no;   // wraps modulo 2^32
                if (offset >= SLOTS)
                begin
                    w = '{kind: KIND_DROP, frame: frame_no, running: acq_on, last: 1'b1};
                    queue_word(w);
                    return;
                end
                slot = (head_idx + offset) % SLOTS;
                // extra tile for a frame already complete: absorbed
                if (slot_tally[slot] >= need && slot_held[slot])
                    return;
                slot_held[slot]  = 1'b1;
                slot_tally[slot] = slot_tally[slot] + 1;
                if (slot_tally[slot] < need || !acq_on)
                    return;
                // release walk from the head, capped per walk
                while (n < RESULT_LIMIT)
                begin
                    idx = head_idx;
                    if (!slot_held[idx] || slot_tally[idx] < need)
                        break;
                    w = '{kind: KIND_RELEASE, frame: head_no, running: acq_on, last: 1'b0};
                    queue_word(w);
                    n++;
                    slot_held[idx]  = 1'b0;
                    slot_tally[idx] = 0;
                    head_no  = head_no + 1;
                    head_idx = (idx + 1) % SLOTS;
                end
                if (n > 0)
                    pending_words[pending_words.size() - 1].last = 1'b1;
            end
            default: ;   // unused opcode: ignored
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sink side: random back-pressure and word checking
    // ------------------------------------------------------------------
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    frame_word_t want;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected word: kind %0d frame %h last %0d",
                       m_tuser, m_tdata[FRAME_W-1:0], m_tlast);
                err_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (m_tuser !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, m_tuser);
                    err_count++;
                end
                if (m_tdata[FRAME_W-1:0] !== want.frame)
                begin
                    $error("out_frame: expected %h, got %h", want.frame,
                           m_tdata[FRAME_W-1:0]);
                    err_count++;
                end
                if (m_tdata[FRAME_W] !== want.running)
                begin
                    $error("running: expected %0d, got %0d", want.running,
                           m_tdata[FRAME_W]);
                    err_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, m_tlast);
                    err_count++;
                end
                if (want.kind == KIND_DROP)
                    drops++;
                else
                    releases++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------
    // Send one word; tvalid stays high afterwards so back-to-back words
    // follow without a gap. Idle cycles lower it first.
    task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [FRAME_W-1:0] frame_no);
        while ($urandom_range(99) < src_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= frame_no;
        do
            @(posedge clk);
        while (!s_tready);
        track_word(op, frame_no);
        words_in++;
    endtask

    // Stop sending, wait for every due word, then cover a full walk that
    // may still be running for a word that produced nothing.
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (WALK_CYCLES) @(posedge clk);
    endtask

    task automatic write_tile_count(input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        tiles_cfg = value;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Frame completed while stopped is released by the first walk after start.
    task automatic test_release_order();
        write_tile_count(5'd1);
        send_word(OP_TILE, head_no);
        send_word(OP_START, '0);
        send_word(OP_TILE, head_no + 1);
    endtask

    // Held frame, absorbed extra tile, ignored opcode, walk stopping at a gap.
    task automatic test_held_and_extra_tiles();
        logic [FRAME_W-1:0] h;
        h = head_no;
        send_word(OP_REFUSE, '0);
        send_word(OP_TILE, h);
        send_word(OP_TILE, h);              // already complete: absorbed
        send_word(OP_UNUSED, '1);
        send_word(OP_START, '0);
        send_word(OP_TILE, h + 2);          // releases h, stops at the gap
        send_word(OP_TILE, h + 1);          // fills the gap: h+1, h+2
    endtask

    // Frames below the head and past the window drop; the far edge is kept
    // (and left pending for the long walk).
    task automatic test_window_edges();
        logic [FRAME_W-1:0] h;
        h = head_no;
        send_word(OP_TILE, h - 1);
        send_word(OP_TILE, 32'hFFFF_FFFF);
        send_word(OP_TILE, h + SLOTS);
        send_word(OP_TILE, 32'hAAAA_AAAA);
        send_word(OP_TILE, 32'h5555_5555);
        send_word(OP_TILE, h + SLOTS - 1);  // complete, but the head is empty
    endtask

    // Whole window complete while stopped, then one walk releases all 16.
    task automatic test_long_walk();
        logic [FRAME_W-1:0] h;
        settle();
        write_tile_count(5'd0);             // behaves as one tile per frame
        h = head_no;
        send_word(OP_REFUSE, '0);
        for (int i = 1; i < SLOTS - 1; i++)
            send_word(OP_TILE, h + i);
        send_word(OP_START, '0);
        send_word(OP_TILE, h);
        settle();                           // hold off until the walk drains
    endtask

    // Partly filled frames become complete when the count is lowered.
    task automatic test_count_lowered();
        logic [FRAME_W-1:0] h;
        write_tile_count(5'd3);
        h = head_no;
        send_word(OP_TILE, h);
        send_word(OP_TILE, h);
        send_word(OP_TILE, h + 1);
        send_word(OP_TILE, h + 1);
        settle();
        write_tile_count(5'd2);
        send_word(OP_TILE, h + 2);
        send_word(OP_TILE, h + 2);          // releases h .. h+2
        settle();
    endtask

    // Mostly tiles near the head, some noise: random frames, frames just
    // below the head, start/refusal and the unused opcode.
    task automatic test_random_traffic(input int count, input int span, input int src_pct,
                                       input int sink_pct, input logic [CFG_W-1:0] tiles);
        int                 pick;
        logic [FRAME_W-1:0] f;
        write_tile_count(tiles);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 66)
                send_word(OP_TILE, head_no + $urandom_range(span));
            else if (pick < 74)
                send_word(OP_TILE, $urandom);
            else if (pick < 78)
                send_word(OP_TILE, head_no - $urandom_range(4, 1));
            else if (pick < 90)
                send_word(OP_START, $urandom);
            else if (pick < 95)
                send_word(OP_REFUSE, $urandom);
            else
            begin
                f = $urandom;
                send_word(OP_UNUSED, f);
            end
        end
        settle();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_release_order();
        test_held_and_extra_tiles();
        test_window_edges();
        test_long_walk();
        test_count_lowered();

        // phases: no idling, source idle, sink stalls, both; count extremes
        test_random_traffic(18, 17, 0, 0, 5'd1);
        test_random_traffic(18, 6, 65, 0, 5'd2);
        test_random_traffic(18, 6, 0, 65, 5'd3);
        test_random_traffic(17, 0, 13, 13, 5'd31);

        $display("Run: %0d words in, %0d frames released, %0d tiles dropped",
                 words_in, releases, drops);
        $display("Tile count written %0d times (0 to 31), four idle patterns",
                 cfg_writes);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #(4_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/tfct_pkg.sv
hdl/tile_frame_completion_tracker.sv
tb/sv/tb.sv
